// ===== src/xtea_pkg.sv =====
// Shared types and constants for the XTEA block cipher.
// Used by xtea_cell and xtea_block_cipher; depends on nothing else.
package xtea_pkg;

   localparam int unsigned CYCLE_COUNT = 32;
   localparam int unsigned STAGE_COUNT = 2 * CYCLE_COUNT;

   localparam logic [31:0] DELTA = 32'h9e3779b9;
   localparam logic [63:0] DEC_SUM_PRODUCT = 64'(DELTA) * 64'(CYCLE_COUNT);
   localparam logic [31:0] DEC_SUM_INIT = DEC_SUM_PRODUCT[31:0];

   localparam logic [1:0] KEY_WORD_ZERO_IDX  = 2'd0;
   localparam logic [1:0] KEY_WORD_ONE_IDX   = 2'd1;
   localparam logic [1:0] KEY_WORD_TWO_IDX   = 2'd2;
   localparam logic [1:0] KEY_WORD_THREE_IDX = 2'd3;

   localparam logic KIND_ENCRYPT = 1'b0;
   localparam logic KIND_DECRYPT = 1'b1;

   typedef logic [3:0][31:0] key_type;

   // One item in flight: the word pair is kept in swapped form, so that every
   // cell updates the second word from the first and then exchanges them.
   typedef struct packed {
      logic        kind;
      logic        phase;
      logic [31:0] sum;
      logic [31:0] upper;
      logic [31:0] lower;
   } stage_type;

endpackage

// ===== src/xtea_cell.sv =====
// One half-round cell of the XTEA chain, with its stage register.
// Depends on xtea_pkg for the stage and key types.
module xtea_cell import xtea_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  logic      prev_valid,
   input  stage_type prev_stage,
   input  key_type   key,
   output logic      valid_out,
   output stage_type stage_out
);

   logic      valid_ff, valid_in;
   stage_type stage_ff, stage_in;

   logic [31:0] mix;
   logic [31:0] round_key;
   logic [31:0] feistel;
   logic [1:0]  key_sel;
   logic        use_high;

   always_comb begin
      // Encryption reads the low selector on the first half and the high one
      // on the second; decryption runs the other way round.
      use_high  = prev_stage.kind ^ prev_stage.phase;
      key_sel   = use_high ? prev_stage.sum[12:11] : prev_stage.sum[1:0];
      mix       = ((prev_stage.upper << 4) ^ (prev_stage.upper >> 5)) + prev_stage.upper;
      round_key = prev_stage.sum + key[key_sel];
      feistel   = mix ^ round_key;

      stage_in.kind  = prev_stage.kind;
      stage_in.phase = ~prev_stage.phase;
      stage_in.lower = prev_stage.upper;
      if (prev_stage.kind == KIND_DECRYPT) begin
         stage_in.upper = prev_stage.lower - feistel;
      end else begin
         stage_in.upper = prev_stage.lower + feistel;
      end
      // The running sum moves between the two halves of a cycle.
      if (prev_stage.phase) begin
         stage_in.sum = prev_stage.sum;
      end else if (prev_stage.kind == KIND_DECRYPT) begin
         stage_in.sum = prev_stage.sum - DELTA;
      end else begin
         stage_in.sum = prev_stage.sum + DELTA;
      end

      valid_in = load ? prev_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;

endmodule

// ===== src/xtea_block_cipher.sv =====
// XTEA block cipher top level: key registers, cell chain and flow control.
// Depends on xtea_pkg and xtea_cell.
//
// This block encrypts or decrypts one 64-bit block per item with XTEA under
// a 128-bit key held in four 32-bit registers written through the csr_ port
// (index 0 to 3, key word zero to three; keys are to be written while no
// item is in flight). The block is a chain of 2*CYCLE_COUNT identical
// half-round cells, 64 with the default CYCLE_COUNT of 32, each with its own stage
// register. An item enters the first stage at the edge that accepts it and
// moves on one stage per edge while the stage after it loads, until its
// result shows on the rsp_ port from the last stage register. One new item
// can enter on every clock cycle while req_stall is low.
// The last cell's register is the output register. Each stage loads when it
// is empty or when the stage after it moves on, so a stalled result holds
// back only the items between it and the nearest empty stage behind it, and
// req_stall is high only when every stage holds an item and rsp_stall is
// high. Encryption and decryption items may be mixed freely in the chain.
module xtea_block_cipher import xtea_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [31:0] req_left_in,
   input  logic [31:0] req_right_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_left_out,
   output logic [31:0] rsp_right_out,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   key_type key_ff, key_in;

   logic [STAGE_COUNT-1:0] valid;
   stage_type              stage [STAGE_COUNT];
   logic [STAGE_COUNT:0]   load;
   stage_type              first_stage;
   stage_type              last_stage;

   // Key register writes.
   always_comb begin
      key_in = key_ff;
      if (csr_write) begin
         case (csr_index)
            KEY_WORD_ZERO_IDX:  key_in[0] = csr_data;
            KEY_WORD_ONE_IDX:   key_in[1] = csr_data;
            KEY_WORD_TWO_IDX:   key_in[2] = csr_data;
            KEY_WORD_THREE_IDX: key_in[3] = csr_data;
            default:            key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   // The incoming item enters in swapped form: for encryption the chain
   // carries (right, left), for decryption (left, right). The sum starts at
   // zero for encryption and at delta times the cycle count for decryption.
   always_comb begin
      first_stage.kind  = req_kind;
      first_stage.phase = 1'b0;
      if (req_kind == KIND_DECRYPT) begin
         first_stage.sum   = DEC_SUM_INIT;
         first_stage.upper = req_left_in;
         first_stage.lower = req_right_in;
      end else begin
         first_stage.sum   = '0;
         first_stage.upper = req_right_in;
         first_stage.lower = req_left_in;
      end
   end

   // A stage loads when it is empty or when its successor loads.
   assign load[STAGE_COUNT] = ~rsp_stall;

   for (genvar i = 0; i < STAGE_COUNT; i++) begin : g_chain
      assign load[i] = ~valid[i] | load[i+1];

      if (i == 0) begin : g_head
         xtea_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .load       (load[i]),
            .prev_valid (req_valid),
            .prev_stage (first_stage),
            .key        (key_ff),
            .valid_out  (valid[i]),
            .stage_out  (stage[i])
         );
      end else begin : g_body
         xtea_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .load       (load[i]),
            .prev_valid (valid[i-1]),
            .prev_stage (stage[i-1]),
            .key        (key_ff),
            .valid_out  (valid[i]),
            .stage_out  (stage[i])
         );
      end
   end

   assign req_stall  = ~load[0];
   assign last_stage = stage[STAGE_COUNT-1];
   assign rsp_valid  = valid[STAGE_COUNT-1];

   // After an even number of half rounds the pair is back in entry order,
   // so the swap undoes itself per kind.
   always_comb begin
      if (last_stage.kind == KIND_DECRYPT) begin
         rsp_left_out  = last_stage.upper;
         rsp_right_out = last_stage.lower;
      end else begin
         rsp_left_out  = last_stage.lower;
         rsp_right_out = last_stage.upper;
      end
   end

   // An accepted item always lands in the first stage.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid[0])
      else $error("accepted item did not enter the first stage");

   // The input is held back only when the whole chain is full and blocked.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&valid) && rsp_stall))
      else $error("input stalled while the chain has room");

   // A finished item has run an even number of half rounds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (last_stage.phase == 1'b0))
      else $error("result left the chain in the middle of a cycle");

   // The running sum ends where the other direction starts.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((last_stage.kind == KIND_ENCRYPT && last_stage.sum == DEC_SUM_INIT)
                  || (last_stage.kind == KIND_DECRYPT && last_stage.sum == 32'd0)))
      else $error("running sum out of step at the end of the chain");

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the XTEA block cipher (xtea_block_cipher).
// Uses xtea_pkg for the cycle count, delta, kind codes and key register indexes.
// The bench predicts each block in its own code and compares it with the block's result.
module tb import xtea_pkg::*; ();

   // Cycles with no accepted item or result before the run is given up. The worst quiet
   // stretch is a long result stall plus the passage of an item through the 64-stage chain, plus the
   // key writes between phases.
   localparam int unsigned QUIET_LIMIT = 3000;
   // Cycles to wait after the last result so that a stray extra result shows up.
   localparam int unsigned DRAIN_CYCLES = 2 * STAGE_COUNT;
   localparam int unsigned RANDOM_PHASES = 8;
   localparam int unsigned BLOCKS_PER_PHASE = 50;
   localparam int unsigned REPORT_LIMIT = 10;

   typedef struct {
      logic        kind;
      logic [31:0] left;
      logic [31:0] right;
   } plain_block_type;

   typedef struct {
      logic [31:0] left;
      logic [31:0] right;
   } cipher_pair_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = KIND_ENCRYPT;
   logic [31:0] req_left_in = '0;
   logic [31:0] req_right_in = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_left_out;
   logic [31:0] rsp_right_out;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = KEY_WORD_ZERO_IDX;
   logic [31:0] csr_data = '0;

   // Blocks waiting to be offered, and the transformed blocks still owed by the
   // cipher, oldest first.
   plain_block_type blocks_to_send[$];
   cipher_pair_type cipher_words_due[$];

   // The bench's copy of the key, kept in step with every register write.
   logic [31:0] key_copy[4] = '{32'h0, 32'h0, 32'h0, 32'h0};
   const logic [1:0] key_slot[4] =
      '{KEY_WORD_ZERO_IDX, KEY_WORD_ONE_IDX, KEY_WORD_TWO_IDX, KEY_WORD_THREE_IDX};

   // When this is low, both sides run without gaps or stalls for a whole phase.
   bit          idling_on = 1'b1;
   int unsigned fail_count = 0;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   int unsigned stall_draw;
   int unsigned quiet_cycles = 0;
   plain_block_type next_block;
   cipher_pair_type due;

   xtea_block_cipher dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_kind     (req_kind),
      .req_left_in  (req_left_in),
      .req_right_in (req_right_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_left_out (rsp_left_out),
      .rsp_right_out(rsp_right_out),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // The XTEA round function applied to one word: shifted copies mixed back in.
   function automatic logic [31:0] feistel_mix(input logic [31:0] word);
      return ((word << 4) ^ (word >> 5)) + word;
   endfunction

   // Runs the whole XTEA round loop on one block under the current key copy. Encryption
   // walks the running sum up from zero. Decryption starts it at delta times
   // the cycle count, wrapped to 32 bits, and undoes the halves in the opposite
   // order.
   function automatic cipher_pair_type xtea_transform(input plain_block_type blk);
      logic [31:0]     v0;
      logic [31:0]     v1;
      logic [31:0]     sum;
      cipher_pair_type res;
      v0 = blk.left;
      v1 = blk.right;
      if (blk.kind == KIND_ENCRYPT) begin
         sum = '0;
         for (int c = 0; c < CYCLE_COUNT; c++) begin
            v0 += feistel_mix(v1) ^ (sum + key_copy[sum[1:0]]);
            sum += DELTA;
            v1 += feistel_mix(v0) ^ (sum + key_copy[sum[12:11]]);
         end
      end else begin
         sum = DELTA * 32'(CYCLE_COUNT);
         for (int c = 0; c < CYCLE_COUNT; c++) begin
            v1 -= feistel_mix(v0) ^ (sum + key_copy[sum[12:11]]);
            sum -= DELTA;
            v0 -= feistel_mix(v1) ^ (sum + key_copy[sum[1:0]]);
         end
      end
      res.left = v0;
      res.right = v1;
      return res;
   endfunction

   // Random word with a bias toward the edges: all zeros, all ones and single
   // set bits turn up far more often than a plain draw would give them.
   function automatic logic [31:0] edgy_word();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         return 32'h0000_0000;
      end else if (pick == 1) begin
         return 32'hffff_ffff;
      end else if (pick == 2) begin
         return 32'h1 << $urandom_range(0, 31);
      end
      return $urandom();
   endfunction

   // Gap before the next block is offered: mostly none, sometimes a few
   // cycles, now and then a long pause.
   function automatic int unsigned sender_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         return 0;
      end else if (pick < 92) begin
         return $urandom_range(1, 4);
      end
      return $urandom_range(5, 30);
   endfunction

   // Length of a result stall. The rare long ones outlast the chain depth, so
   // the chain fills up and the cipher has to push back on the input side.
   function automatic int unsigned receiver_stall();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         return 0;
      end else if (pick < 92) begin
         return $urandom_range(1, 4);
      end else if (pick < 98) begin
         return $urandom_range(5, 20);
      end
      return $urandom_range(STAGE_COUNT, STAGE_COUNT + 70);
   endfunction

   // Writes all four key words, one per clock, and updates the key copy with
   // them. It is only called while no block is in flight, so no prediction
   // ever sees a half-written key.
   task automatic load_key(input logic [31:0] k0, input logic [31:0] k1,
                           input logic [31:0] k2, input logic [31:0] k3);
      logic [31:0] words[4];
      words = '{k0, k1, k2, k3};
      for (int i = 0; i < 4; i++) begin
         @(posedge clock);
         csr_write <= 1'b1;
         csr_index <= key_slot[i];
         csr_data <= words[i];
         key_copy[key_slot[i]] = words[i];
      end
      @(posedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // Both kinds over every pairing of two chosen words in the two halves.
   task automatic queue_corner_blocks(input logic [31:0] a, input logic [31:0] b);
      logic kinds[2];
      kinds = '{KIND_ENCRYPT, KIND_DECRYPT};
      foreach (kinds[k]) begin
         blocks_to_send.push_back('{kinds[k], a, a});
         blocks_to_send.push_back('{kinds[k], b, b});
         blocks_to_send.push_back('{kinds[k], a, b});
         blocks_to_send.push_back('{kinds[k], b, a});
      end
   endtask

   // Returns at a falling edge once every block has been accepted and every
   // result has come back.
   task automatic wait_until_drained();
      do
         @(negedge clock);
      while (blocks_to_send.size() != 0 || req_valid || cipher_words_due.size() != 0);
   endtask

   // Sender. On every accepted item the expected result is computed right away
   // with the key copy, which cannot change while items are in flight. A
   // stalled item is held unchanged; otherwise the next block goes out after
   // its random gap.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            cipher_words_due.push_back(xtea_transform('{req_kind, req_left_in, req_right_in}));
         end
         if (req_valid && req_stall) begin
            // Hold the stalled item as it is.
         end else if (send_gap != 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (blocks_to_send.size() != 0) begin
            next_block = blocks_to_send.pop_front();
            req_kind <= next_block.kind;
            req_left_in <= next_block.left;
            req_right_in <= next_block.right;
            req_valid <= 1'b1;
            send_gap = idling_on ? sender_gap() : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver. Each accepted result is matched against the oldest expected
   // block, field by field; then the stall for the next cycle is chosen.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (cipher_words_due.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("Result left %h right %h arrived with no block outstanding",
                           rsp_left_out, rsp_right_out);
               end
            end else begin
               due = cipher_words_due.pop_front();
               if (rsp_left_out !== due.left || rsp_right_out !== due.right) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("Block mismatch: left expected %h got %h, right expected %h got %h",
                              due.left, rsp_left_out, due.right, rsp_right_out);
                  end
               end
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_draw = idling_on ? receiver_stall() : 0;
            if (stall_draw != 0) begin
               stall_left = stall_draw - 1;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Watchdog: a run that stops moving for too long has lost an item somewhere.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Test sequence. The directed part comes first: corner words under the
   // all-zero reset key, then under an all-ones key, then alternating bit
   // patterns under a mixed key. Random phases follow, each with a fresh key
   // that is sometimes made of extreme words. Every third phase runs without
   // gaps or stalls so that the chain also sees back-to-back traffic.
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_corner_blocks(32'h0000_0000, 32'hffff_ffff);
      wait_until_drained();

      load_key(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      queue_corner_blocks(32'h0000_0000, 32'hffff_ffff);
      wait_until_drained();

      load_key(32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210);
      queue_corner_blocks(32'h5555_5555, 32'haaaa_aaaa);
      wait_until_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         load_key(edgy_word(), edgy_word(), edgy_word(), edgy_word());
         idling_on = (phase % 3 != 1);
         for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
            blocks_to_send.push_back('{$urandom_range(0, 1) ? KIND_DECRYPT : KIND_ENCRYPT,
                                       edgy_word(), edgy_word()});
         end
         wait_until_drained();
      end

      // Give a stray extra result time to come out before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && cipher_words_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
